// ===== rtl/alt_pkg.sv =====
// Shared types, constants and helper functions of the line terminal.
// Used by the controller, the datapath and the top level; no dependencies.
package alt_pkg;

    localparam int LINE_LEN  = 64;
    localparam int PARAM_CAP = 48;

    localparam int ADDR_W  = $clog2(LINE_LEN);
    localparam int CNT_W   = $clog2(LINE_LEN + 1);
    localparam int PCNT_W  = 6;
    localparam int CHAR_W  = 16;
    localparam int PEN_W   = 6;
    localparam int CELL_W  = PEN_W + CHAR_W;
    localparam int VAL_W   = 10;
    localparam int ROLE_W  = 3;

    localparam logic [VAL_W-1:0] VALUE_MAX = 10'd1023;

    localparam logic [CHAR_W-1:0] CH_BS        = 16'h0008;
    localparam logic [CHAR_W-1:0] CH_LF        = 16'h000a;
    localparam logic [CHAR_W-1:0] CH_CR        = 16'h000d;
    localparam logic [CHAR_W-1:0] CH_ESC       = 16'h001b;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0   = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9   = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_SEMI      = 16'h003b;
    localparam logic [CHAR_W-1:0] CH_PARAM_MAX = 16'h003f;
    localparam logic [CHAR_W-1:0] CH_FINAL_EL  = 16'h004b;
    localparam logic [CHAR_W-1:0] CH_LBRACKET  = 16'h005b;
    localparam logic [CHAR_W-1:0] CH_FINAL_SGR = 16'h006d;

    localparam logic [VAL_W-1:0] EL_TO_CURSOR = 10'd1;
    localparam logic [VAL_W-1:0] EL_ALL       = 10'd2;

    localparam logic [ROLE_W-1:0] ROLE_DEFAULT = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_SUCCESS = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_WARNING = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_DANGER  = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_MUTED   = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_ACCENT  = 3'd5;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } esc_mode_t;

    typedef struct packed {
        logic accept;
        logic fill_step;
        logic blank_step;
        logic emit_load;
    } dp_cmd_t;

    typedef struct packed {
        logic go_fill;
        logic go_blank;
        logic go_emit;
        logic fill_last;
        logic blank_last;
        logic emit_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [VAL_W-1:0] add_digit(input logic [VAL_W-1:0] v,
                                                   input logic [3:0] d);
        logic [13:0] n;
        n = 14'(v) * 14'd10 + 14'(d);
        return (n > 14'(VALUE_MAX)) ? VALUE_MAX : n[VAL_W-1:0];
    endfunction

    function automatic logic [PEN_W-1:0] with_role(input logic [PEN_W-1:0] p,
                                                   input logic [ROLE_W-1:0] r);
        return {r, p[2:0]};
    endfunction

    function automatic logic [PEN_W-1:0] apply_sgr(input logic [PEN_W-1:0] p,
                                                   input logic ok,
                                                   input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] code;
        logic [PEN_W-1:0] r;
        code = ok ? v : '0;
        r = p;
        case (code)
            10'd0:         r = '0;
            10'd1:         r = p | 6'b000001;
            10'd2:         r = p | 6'b000010;
            10'd3:         r = p | 6'b000100;
            10'd22:        r = p & 6'b111100;
            10'd23:        r = p & 6'b111011;
            10'd30, 10'd39: r = with_role(p, ROLE_DEFAULT);
            10'd31:        r = with_role(p, ROLE_DANGER);
            10'd32:        r = with_role(p, ROLE_SUCCESS);
            10'd33:        r = with_role(p, ROLE_WARNING);
            10'd34, 10'd36: r = with_role(p, ROLE_ACCENT);
            10'd90:        r = with_role(p, ROLE_MUTED);
            default:       r = p;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/alt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/alt_ctrl.sv =====
// Sequencer of the line terminal: input acceptance, fill, blank and emit walks.
// Depends on alt_pkg.
module alt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  alt_pkg::dp_status_t status,
    output alt_pkg::dp_cmd_t    cmd
);
    import alt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FILL  = 5'b00010,
        S_BLANK = 5'b00100,
        S_RD    = 5'b01000,
        S_CAP   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (status.go_fill)
                    begin
                        state_next = S_FILL;
                    end
                    else if (status.go_blank)
                    begin
                        state_next = S_BLANK;
                    end
                    else if (status.go_emit)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BLANK:
            begin
                cmd.blank_step = 1'b1;
                if (status.blank_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next = status.emit_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/alt_dp.sv =====
// Datapath of the line terminal: escape parser, pen, cursor, line buffer, output.
// Depends on alt_pkg and alt_ram.
module alt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [alt_pkg::CHAR_W-1:0]          char_code,
    input  alt_pkg::dp_cmd_t                    cmd,
    output alt_pkg::dp_status_t                 status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [alt_pkg::CHAR_W-1:0]          cell_char,
    output logic                                cell_bold,
    output logic                                cell_faint,
    output logic                                cell_italic,
    output logic [alt_pkg::ROLE_W-1:0]          cell_role,
    output logic                                line_empty,
    output logic                                last_cell
);
    import alt_pkg::*;

    esc_mode_t          esc_mode_reg, esc_mode_next;
    logic [PCNT_W-1:0]  param_count_reg, param_count_next;
    logic [VAL_W-1:0]   token_value_reg, token_value_next;
    logic               token_ok_reg, token_ok_next;
    logic [VAL_W-1:0]   whole_value_reg, whole_value_next;
    logic               whole_ok_reg, whole_ok_next;
    logic [PEN_W-1:0]   shadow_pen_reg, shadow_pen_next;
    logic [PEN_W-1:0]   pen_reg, pen_next;
    logic [CNT_W-1:0]   line_length_reg, line_length_next;
    logic [CNT_W-1:0]   cursor_col_reg, cursor_col_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [CHAR_W-1:0]  hold_char_reg, hold_char_next;
    logic               out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]  out_cell_reg, out_cell_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_last_reg, out_last_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [CELL_W-1:0]  ram_rdata;

    logic               is_param;
    logic               is_digit;
    logic [3:0]         digit;
    logic [VAL_W-1:0]   el_mode;
    logic [CNT_W-1:0]   upto;
    logic [CNT_W-1:0]   idx_plus;
    logic [PEN_W-1:0]   sgr_pen;

    assign is_param = (char_code >= CH_SPACE) && (char_code <= CH_PARAM_MAX);
    assign is_digit = (char_code >= CH_DIGIT_0) && (char_code <= CH_DIGIT_9);
    assign digit    = char_code[3:0];
    assign el_mode  = whole_ok_reg ? whole_value_reg : '0;
    assign upto     = (cursor_col_reg < line_length_reg) ? cursor_col_reg : line_length_reg;
    assign idx_plus = {1'b0, idx_reg} + CNT_W'(1);
    assign sgr_pen  = apply_sgr(shadow_pen_reg, token_ok_reg, token_value_reg);

    always_comb
    begin
        status.go_fill    = (esc_mode_reg == MODE_NORMAL) && (char_code >= CH_SPACE)
                            && (cursor_col_reg < CNT_W'(LINE_LEN))
                            && (line_length_reg < cursor_col_reg);
        status.go_blank   = (esc_mode_reg == MODE_CSI) && (char_code == CH_FINAL_EL)
                            && (el_mode == EL_TO_CURSOR) && (upto != '0);
        status.go_emit    = (esc_mode_reg == MODE_NORMAL) && (char_code == CH_LF);
        status.fill_last  = (line_length_reg == cursor_col_reg);
        status.blank_last = (idx_plus == upto);
        status.emit_last  = (line_length_reg == '0) || (idx_plus == line_length_reg);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        esc_mode_next    = esc_mode_reg;
        param_count_next = param_count_reg;
        token_value_next = token_value_reg;
        token_ok_next    = token_ok_reg;
        whole_value_next = whole_value_reg;
        whole_ok_next    = whole_ok_reg;
        shadow_pen_next  = shadow_pen_reg;
        pen_next         = pen_reg;
        line_length_next = line_length_reg;
        cursor_col_next  = cursor_col_reg;
        idx_next         = idx_reg;
        hold_char_next   = hold_char_reg;
        out_cell_next    = out_cell_reg;
        out_empty_next   = out_empty_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ram_we           = 1'b0;
        ram_waddr        = cursor_col_reg[ADDR_W-1:0];
        ram_wdata        = {pen_reg, char_code};

        if (cmd.accept)
        begin
            case (esc_mode_reg)
                MODE_ESC:
                begin
                    if (char_code == CH_LBRACKET)
                    begin
                        esc_mode_next    = MODE_CSI;
                        param_count_next = '0;
                        token_value_next = '0;
                        token_ok_next    = 1'b1;
                        whole_value_next = '0;
                        whole_ok_next    = 1'b1;
                        shadow_pen_next  = pen_reg;
                    end
                    else
                    begin
                        esc_mode_next = MODE_NORMAL;
                    end
                end
                MODE_CSI:
                begin
                    if (is_param)
                    begin
                        if (param_count_reg < PCNT_W'(PARAM_CAP))
                        begin
                            param_count_next = param_count_reg + PCNT_W'(1);
                            if (is_digit)
                            begin
                                token_value_next = add_digit(token_value_reg, digit);
                                whole_value_next = add_digit(whole_value_reg, digit);
                            end
                            else
                            begin
                                whole_ok_next = 1'b0;
                                if (char_code == CH_SEMI)
                                begin
                                    shadow_pen_next  = sgr_pen;
                                    token_value_next = '0;
                                    token_ok_next    = 1'b1;
                                end
                                else
                                begin
                                    token_ok_next = 1'b0;
                                end
                            end
                        end
                    end
                    else
                    begin
                        esc_mode_next = MODE_NORMAL;
                        if (char_code == CH_FINAL_SGR)
                        begin
                            shadow_pen_next  = sgr_pen;
                            pen_next         = sgr_pen;
                            token_value_next = '0;
                            token_ok_next    = 1'b1;
                        end
                        else if (char_code == CH_FINAL_EL)
                        begin
                            if (el_mode == EL_ALL)
                            begin
                                line_length_next = '0;
                                cursor_col_next  = '0;
                            end
                            else if (el_mode == EL_TO_CURSOR)
                            begin
                                idx_next = '0;
                            end
                            else if (cursor_col_reg < line_length_reg)
                            begin
                                line_length_next = cursor_col_reg;
                            end
                        end
                    end
                end
                default:
                begin
                    if (char_code == CH_ESC)
                    begin
                        esc_mode_next = MODE_ESC;
                    end
                    else if (char_code == CH_CR)
                    begin
                        cursor_col_next = '0;
                    end
                    else if (char_code == CH_LF)
                    begin
                        idx_next = '0;
                    end
                    else if (char_code == CH_BS)
                    begin
                        if (cursor_col_reg != '0)
                        begin
                            cursor_col_next = cursor_col_reg - CNT_W'(1);
                        end
                    end
                    else if (char_code >= CH_SPACE)
                    begin
                        if (status.go_fill)
                        begin
                            hold_char_next = char_code;
                        end
                        else if (cursor_col_reg < CNT_W'(LINE_LEN))
                        begin
                            ram_we          = 1'b1;
                            cursor_col_next = cursor_col_reg + CNT_W'(1);
                            if (cursor_col_reg == line_length_reg)
                            begin
                                line_length_next = line_length_reg + CNT_W'(1);
                            end
                        end
                    end
                end
            endcase
        end

        // Pad with spaces up to the cursor, then place the held character.
        if (cmd.fill_step)
        begin
            ram_we           = 1'b1;
            line_length_next = line_length_reg + CNT_W'(1);
            if (line_length_reg < cursor_col_reg)
            begin
                ram_waddr = line_length_reg[ADDR_W-1:0];
                ram_wdata = {{PEN_W{1'b0}}, CH_SPACE};
            end
            else
            begin
                ram_wdata       = {pen_reg, hold_char_reg};
                cursor_col_next = cursor_col_reg + CNT_W'(1);
            end
        end

        if (cmd.blank_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg;
            ram_wdata = {{PEN_W{1'b0}}, CH_SPACE};
            idx_next  = idx_reg + ADDR_W'(1);
        end

        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = status.emit_last;
            if (line_length_reg == '0)
            begin
                out_cell_next  = '0;
                out_empty_next = 1'b1;
            end
            else
            begin
                out_cell_next  = ram_rdata;
                out_empty_next = 1'b0;
            end
            if (status.emit_last)
            begin
                line_length_next = '0;
                cursor_col_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + ADDR_W'(1);
            end
        end
    end

    alt_ram #(
        .WIDTH (CELL_W),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_mode_reg    <= MODE_NORMAL;
            param_count_reg <= '0;
            token_value_reg <= '0;
            token_ok_reg    <= 1'b1;
            whole_value_reg <= '0;
            whole_ok_reg    <= 1'b1;
            shadow_pen_reg  <= '0;
            pen_reg         <= '0;
            line_length_reg <= '0;
            cursor_col_reg  <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            esc_mode_reg    <= esc_mode_next;
            param_count_reg <= param_count_next;
            token_value_reg <= token_value_next;
            token_ok_reg    <= token_ok_next;
            whole_value_reg <= whole_value_next;
            whole_ok_reg    <= whole_ok_next;
            shadow_pen_reg  <= shadow_pen_next;
            pen_reg         <= pen_next;
            line_length_reg <= line_length_next;
            cursor_col_reg  <= cursor_col_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_char_reg <= hold_char_next;
        out_cell_reg  <= out_cell_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign cell_char   = out_cell_reg[CHAR_W-1:0];
    assign cell_bold   = out_cell_reg[CHAR_W];
    assign cell_faint  = out_cell_reg[CHAR_W+1];
    assign cell_italic = out_cell_reg[CHAR_W+2];
    assign cell_role   = out_cell_reg[CELL_W-1:CHAR_W+3];
    assign line_empty  = out_empty_reg;
    assign last_cell   = out_last_reg;

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_col_reg <= CNT_W'(LINE_LEN))
        else $error("cursor column beyond line length limit");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_length_reg <= CNT_W'(LINE_LEN))
        else $error("line length beyond limit");

    a_emit_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && (line_length_reg != '0)) |-> ({1'b0, idx_reg} < line_length_reg))
        else $error("emit index outside the line");

    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && status.emit_last) |=> (line_length_reg == '0))
        else $error("line not cleared after commit");

endmodule

// ===== rtl/ansi_line_terminal.sv =====
// One-line text terminal with ESC [ SGR/EL parsing; top level.
// Ordinary characters, controls and escape bytes are taken one per cycle while idle.
// A character placed past the line end needs a fill walk (one pad cell per cycle);
// EL 1 blanks cells below min(cursor, length); LF emits the line cell by cell,
// paced by the single read port of the line RAM, plus any output stall.
// Reset (rst_n, async, active low) clears parser, pen, cursor and length at once.
module ansi_line_terminal (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [alt_pkg::CHAR_W-1:0]   char_code,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [alt_pkg::CHAR_W-1:0]   cell_char,
    output logic                         cell_bold,
    output logic                         cell_faint,
    output logic                         cell_italic,
    output logic [alt_pkg::ROLE_W-1:0]   cell_role,
    output logic                         line_empty,
    output logic                         last_cell
);
    import alt_pkg::*;

    // Commands go from the sequencer to the datapath, status comes back.
    dp_cmd_t    cmd;
    dp_status_t status;

    alt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath holds the line buffer and a registered output stage, so the
    // last cell of a line may wait while the next item is taken.
    alt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_char   (cell_char),
        .cell_bold   (cell_bold),
        .cell_faint  (cell_faint),
        .cell_italic (cell_italic),
        .cell_role   (cell_role),
        .line_empty  (line_empty),
        .last_cell   (last_cell)
    );

endmodule
